// ----- hdl/assert_macros.svh -----
// Assertion helpers for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define LACB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lacb: implication check failed");

// cond must never hold at a clock edge outside reset.
`define LACB_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("lacb: forbidden condition seen");

`endif

// ----- hdl/lacb_pkg.sv -----
`timescale 1ns / 1ps

package lacb_pkg;

	localparam int COORD_WIDTH    = 32;
	localparam int UNIT_FRAC_BITS = 14;
	localparam int OUT_WIDTH      = UNIT_FRAC_BITS + 2;

	// Block scaling puts the largest magnitude in [2^SCALE_MSB, 2^(SCALE_MSB+1)).
	localparam int SCALE_MSB  = 29;
	localparam int MAG_W      = SCALE_MSB + 1;
	localparam int SQ_W       = 2 * MAG_W + 2;
	localparam int ROOT_W     = MAG_W + 1;
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int QUO_W      = UNIT_FRAC_BITS + 1;
	localparam int DIV_STEPS  = QUO_W;
	localparam int DEN_W      = ROOT_W + 1;
	localparam int REM_W      = DEN_W + QUO_W;
	localparam int NORM_LAT   = SQRT_STEPS + DIV_STEPS + 3;

	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int PROD_W = MAG_W + 1 + OUT_WIDTH;
	localparam int CR_W   = PROD_W + 1;
	localparam int SC_W   = (CR_W > DIFF_W) ? CR_W : DIFF_W;
	localparam int P_W    = $clog2(SC_W);
	localparam int UP_W   = 2 * OUT_WIDTH + 1;

	localparam int PIPE_LAT = 2 * NORM_LAT + 13;
	localparam int UNIT_ONE = 1 << UNIT_FRAC_BITS;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] eye_x;
		logic signed [COORD_WIDTH-1:0] eye_y;
		logic signed [COORD_WIDTH-1:0] eye_z;
		logic signed [COORD_WIDTH-1:0] target_x;
		logic signed [COORD_WIDTH-1:0] target_y;
		logic signed [COORD_WIDTH-1:0] target_z;
		logic signed [COORD_WIDTH-1:0] guide_x;
		logic signed [COORD_WIDTH-1:0] guide_y;
		logic signed [COORD_WIDTH-1:0] guide_z;
	} lacb_in_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] right_x;
		logic signed [OUT_WIDTH-1:0] right_y;
		logic signed [OUT_WIDTH-1:0] right_z;
		logic signed [OUT_WIDTH-1:0] upvec_x;
		logic signed [OUT_WIDTH-1:0] upvec_y;
		logic signed [OUT_WIDTH-1:0] upvec_z;
		logic signed [OUT_WIDTH-1:0] fwd_x;
		logic signed [OUT_WIDTH-1:0] fwd_y;
		logic signed [OUT_WIDTH-1:0] fwd_z;
		logic                        degenerate;
	} lacb_out_t;

endpackage

// ----- hdl/lacb_norm.sv -----
`timescale 1ns / 1ps

// Normalizes a block-scaled vector of three magnitudes: squares, sum, a
// bit-per-stage square root and a bit-per-stage restoring division.
module lacb_norm (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_vld,
	input  logic [2:0][lacb_pkg::MAG_W-1:0]       mag,
	output logic                                  out_vld,
	output logic [2:0][lacb_pkg::QUO_W-1:0]       quo
);
	import lacb_pkg::*;

	localparam logic [SQ_W:0]    SQ_ONE = 1;
	localparam logic [QUO_W-1:0] Q_ONE  = 1;

	logic                           v_s1;
	logic [2:0][MAG_W-1:0]          m_s1;
	logic [2:0][2*MAG_W-1:0]        sq_s1;

	logic [SQRT_STEPS:0]            sv_s;
	logic [SQ_W-1:0]                sx_s [SQRT_STEPS+1];
	logic [SQ_W-1:0]                sr_s [SQRT_STEPS+1];
	logic [2:0][MAG_W-1:0]          sm_s [SQRT_STEPS+1];
	logic [SQ_W:0]                  sbit [SQRT_STEPS];
	logic [SQ_W:0]                  trial [SQRT_STEPS];
	logic [SQ_W-1:0]                sx_n [SQRT_STEPS];
	logic [SQ_W-1:0]                sr_n [SQRT_STEPS];

	logic [DIV_STEPS:0]             dv_s;
	logic [DEN_W-1:0]               dd_s [DIV_STEPS+1];
	logic [2:0][REM_W-1:0]          dr_s [DIV_STEPS+1];
	logic [2:0][QUO_W-1:0]          dq_s [DIV_STEPS+1];
	logic [REM_W-1:0]               dsh [DIV_STEPS];
	logic [2:0][REM_W-1:0]          dr_n [DIV_STEPS];
	logic [2:0][QUO_W-1:0]          dq_n [DIV_STEPS];

	// One root bit per stage.
	always_comb begin
		for (int k = 0; k < SQRT_STEPS; k++) begin
			sbit[k]  = SQ_ONE << (SQ_W - 2 - 2 * k);
			trial[k] = {1'b0, sr_s[k]} + sbit[k];
			if ({1'b0, sx_s[k]} >= trial[k]) begin
				sx_n[k] = sx_s[k] - trial[k][SQ_W-1:0];
				sr_n[k] = (sr_s[k] >> 1) + sbit[k][SQ_W-1:0];
			end else begin
				sx_n[k] = sx_s[k];
				sr_n[k] = sr_s[k] >> 1;
			end
		end
	end

	// One quotient bit per stage, most significant first.
	always_comb begin
		for (int j = 0; j < DIV_STEPS; j++) begin
			dsh[j] = REM_W'(dd_s[j]) << (QUO_W - 1 - j);
			for (int i = 0; i < 3; i++) begin
				if (dr_s[j][i] >= dsh[j]) begin
					dr_n[j][i] = dr_s[j][i] - dsh[j];
					dq_n[j][i] = dq_s[j][i] | (Q_ONE << (QUO_W - 1 - j));
				end else begin
					dr_n[j][i] = dr_s[j][i];
					dq_n[j][i] = dq_s[j][i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			sv_s <= '0;
			dv_s <= '0;
		end else begin
			v_s1    <= in_vld;
			sv_s[0] <= v_s1;
			for (int k = 0; k < SQRT_STEPS; k++) begin
				sv_s[k+1] <= sv_s[k];
			end
			dv_s[0] <= sv_s[SQRT_STEPS];
			for (int j = 0; j < DIV_STEPS; j++) begin
				dv_s[j+1] <= dv_s[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		m_s1 <= mag;
		for (int i = 0; i < 3; i++) begin
			sq_s1[i] <= mag[i] * mag[i];
		end

		sx_s[0] <= SQ_W'(sq_s1[0]) + SQ_W'(sq_s1[1]) + SQ_W'(sq_s1[2]);
		sr_s[0] <= '0;
		sm_s[0] <= m_s1;
		for (int k = 0; k < SQRT_STEPS; k++) begin
			sx_s[k+1] <= sx_n[k];
			sr_s[k+1] <= sr_n[k];
			sm_s[k+1] <= sm_s[k];
		end

		// Numerator m * 2^(F+1) + n over denominator 2n rounds half away from zero.
		dd_s[0] <= {sr_s[SQRT_STEPS][ROOT_W-1:0], 1'b0};
		dq_s[0] <= '0;
		for (int i = 0; i < 3; i++) begin
			dr_s[0][i] <= (REM_W'(sm_s[SQRT_STEPS][i]) << (UNIT_FRAC_BITS + 1))
				+ REM_W'(sr_s[SQRT_STEPS][ROOT_W-1:0]);
		end
		for (int j = 0; j < DIV_STEPS; j++) begin
			dd_s[j+1] <= dd_s[j];
			dr_s[j+1] <= dr_n[j];
			dq_s[j+1] <= dq_n[j];
		end
	end

	assign out_vld = dv_s[DIV_STEPS];
	assign quo     = dq_s[DIV_STEPS];

endmodule

// ----- hdl/look_at_camera_basis_core.sv -----
`timescale 1ns / 1ps
// Throughput: one item per cycle while busy is low; each square root and division resolves one bit per stage.
// busy is high during reset and for the first edge after it, and low from then on.
// Reset clears every valid bit, so items in flight are dropped; done is high for one cycle per result.
// The receiver cannot stall the result, so nothing upstream ever waits on it.

// Look-at camera basis.
// The pipeline runs in three sections. The front forms eye minus target,
// takes magnitudes, finds the leading bit of the largest component and
// shifts every component to a common block scale; the up guide is block
// scaled alongside. The first normalizer turns the scaled difference into
// the forward vector. The middle section forms cross(guide, forward) with
// one register after the products and one after the subtraction, then block
// scales that vector for the second normalizer, which gives the right
// vector. The back section forms cross(forward, right), rounds each
// component half away from zero to the output fraction and saturates it.
// Side data that does not pass through a normalizer rides in a delay line
// of the normalizer's depth. A zero difference, a zero guide or a zero
// cross product marks the item degenerate, and its basis fields go out as
// zeros.
module look_at_camera_basis_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lacb_pkg::lacb_in_t  req,
	output logic                done,
	output lacb_pkg::lacb_out_t res
);
	import lacb_pkg::*;

	localparam logic [UP_W-1:0] UP_HALF = UP_W'(1) << (UNIT_FRAC_BITS - 1);
	localparam logic [UP_W-1:0] UP_SAT  = UP_W'(UNIT_ONE);

	typedef struct packed {
		logic [2:0]            dsg;
		logic [2:0]            gsg;
		logic [2:0][MAG_W-1:0] gsc;
		logic                  dz;
		logic                  gz;
	} side_a_t;

	typedef struct packed {
		logic [2:0]                rsg;
		logic [2:0][OUT_WIDTH-1:0] fw;
		logic                      bad;
	} side_b_t;

	// Index of the highest set bit; zero for a zero word.
	function automatic logic [P_W-1:0] msb_pos(input logic [SC_W-1:0] v);
		logic [P_W-1:0] p;
		p = '0;
		for (int i = 0; i < SC_W; i++) begin
			if (v[i]) begin
				p = P_W'(i);
			end
		end
		return p;
	endfunction

	// Moves the bit at position p to SCALE_MSB, truncating toward zero.
	function automatic logic [MAG_W-1:0] block_shift(input logic [SC_W-1:0] m,
		input logic [P_W-1:0] p);
		logic [SC_W+SCALE_MSB-1:0] w;
		w = {m, {SCALE_MSB{1'b0}}} >> p;
		return w[MAG_W-1:0];
	endfunction

	logic busy_q;
	logic accept;

	// Front section.
	logic                         v_s1, v_s2, v_s3, v_s4;
	logic signed [DIFF_W-1:0]     d_s1 [3];
	logic signed [COORD_WIDTH-1:0] g_s1 [3];
	logic [SC_W-1:0]              dm_s2 [3];
	logic [SC_W-1:0]              gm_s2 [3];
	logic [2:0]                   dsg_s2, gsg_s2;
	logic [SC_W-1:0]              dm_s3 [3];
	logic [SC_W-1:0]              gm_s3 [3];
	logic [2:0]                   dsg_s3, gsg_s3;
	logic [P_W-1:0]               dp_s3, gp_s3;
	logic                         dz_s3, gz_s3;
	logic [2:0][MAG_W-1:0]        dsc_s4, gsc_s4;
	logic [2:0]                   dsg_s4, gsg_s4;
	logic                         dz_s4, gz_s4;

	// First normalizer and its side line.
	logic                         fa_vld;
	logic [2:0][QUO_W-1:0]        fa_quo;
	side_a_t                      dla_q [NORM_LAT];
	side_a_t                      sa_c;
	logic signed [OUT_WIDTH-1:0]  fw_c [3];
	logic signed [MAG_W:0]        gs_c [3];

	// Middle section.
	logic                         v_s5, v_s6, v_s7, v_s8, v_s9;
	logic signed [PROD_W-1:0]     cp_s5 [6];
	logic signed [OUT_WIDTH-1:0]  fw_s5 [3];
	logic signed [OUT_WIDTH-1:0]  fw_s6 [3];
	logic signed [OUT_WIDTH-1:0]  fw_s7 [3];
	logic signed [OUT_WIDTH-1:0]  fw_s8 [3];
	logic signed [OUT_WIDTH-1:0]  fw_s9 [3];
	logic                         bad_s5, bad_s6, bad_s7, bad_s8, bad_s9;
	logic signed [CR_W-1:0]       cr_s6 [3];
	logic [SC_W-1:0]              crm_s7 [3];
	logic [SC_W-1:0]              crm_s8 [3];
	logic [2:0]                   crs_s7, crs_s8, crs_s9;
	logic [P_W-1:0]               crp_s8;
	logic                         crz_s8;
	logic [2:0][MAG_W-1:0]        crsc_s9;

	// Second normalizer and its side line.
	logic                         fb_vld;
	logic [2:0][QUO_W-1:0]        fb_quo;
	side_b_t                      dlb_q [NORM_LAT];
	side_b_t                      sb_c;
	logic signed [OUT_WIDTH-1:0]  rt_c [3];
	logic signed [OUT_WIDTH-1:0]  fwb_c [3];

	// Back section.
	logic                         v_s10, v_s11, v_s12;
	logic signed [2*OUT_WIDTH-1:0] upp_s10 [6];
	logic signed [OUT_WIDTH-1:0]  rt_s10 [3];
	logic signed [OUT_WIDTH-1:0]  rt_s11 [3];
	logic signed [OUT_WIDTH-1:0]  rt_s12 [3];
	logic signed [OUT_WIDTH-1:0]  fw_s10 [3];
	logic signed [OUT_WIDTH-1:0]  fw_s11 [3];
	logic signed [OUT_WIDTH-1:0]  fw_s12 [3];
	logic                         bad_s10, bad_s11, bad_s12;
	logic signed [UP_W-1:0]       ud_s11 [3];
	logic [UP_W-1:0]              um_s12 [3];
	logic [2:0]                   us_s12;
	logic [UP_W-1:0]              rnd_c [3];
	logic signed [OUT_WIDTH-1:0]  up_c [3];

	lacb_out_t                    res_q;
	logic                         done_q;

	assign accept = start & ~busy_q;

	// Control: valid bits advance every cycle, nothing in the pipe ever waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			v_s8    <= 1'b0;
			v_s9    <= 1'b0;
			v_s10   <= 1'b0;
			v_s11   <= 1'b0;
			v_s12   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			busy_q  <= 1'b0;
			v_s1    <= accept;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= fa_vld;
			v_s6    <= v_s5;
			v_s7    <= v_s6;
			v_s8    <= v_s7;
			v_s9    <= v_s8;
			v_s10   <= fb_vld;
			v_s11   <= v_s10;
			v_s12   <= v_s11;
			done_q  <= v_s12;
		end
	end

	// Front section: difference, magnitudes, leading bit, block shift.
	always_ff @(posedge clk) begin
		d_s1[0] <= DIFF_W'(req.eye_x) - DIFF_W'(req.target_x);
		d_s1[1] <= DIFF_W'(req.eye_y) - DIFF_W'(req.target_y);
		d_s1[2] <= DIFF_W'(req.eye_z) - DIFF_W'(req.target_z);
		g_s1[0] <= req.guide_x;
		g_s1[1] <= req.guide_y;
		g_s1[2] <= req.guide_z;

		for (int i = 0; i < 3; i++) begin
			dm_s2[i]  <= SC_W'($unsigned(d_s1[i][DIFF_W-1] ? -d_s1[i] : d_s1[i]));
			gm_s2[i]  <= SC_W'($unsigned(g_s1[i][COORD_WIDTH-1] ? -g_s1[i] : g_s1[i]));
			dsg_s2[i] <= d_s1[i][DIFF_W-1];
			gsg_s2[i] <= g_s1[i][COORD_WIDTH-1];
		end

		dm_s3  <= dm_s2;
		gm_s3  <= gm_s2;
		dsg_s3 <= dsg_s2;
		gsg_s3 <= gsg_s2;
		dp_s3  <= msb_pos(dm_s2[0] | dm_s2[1] | dm_s2[2]);
		gp_s3  <= msb_pos(gm_s2[0] | gm_s2[1] | gm_s2[2]);
		dz_s3  <= ~|(dm_s2[0] | dm_s2[1] | dm_s2[2]);
		gz_s3  <= ~|(gm_s2[0] | gm_s2[1] | gm_s2[2]);

		for (int i = 0; i < 3; i++) begin
			dsc_s4[i] <= block_shift(dm_s3[i], dp_s3);
			gsc_s4[i] <= block_shift(gm_s3[i], gp_s3);
		end
		dsg_s4 <= dsg_s3;
		gsg_s4 <= gsg_s3;
		dz_s4  <= dz_s3;
		gz_s4  <= gz_s3;
	end

	lacb_norm u_norm_fwd (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (v_s4),
		.mag     (dsc_s4),
		.out_vld (fa_vld),
		.quo     (fa_quo)
	);

	// Guide and flags wait out the first normalizer.
	always_ff @(posedge clk) begin
		dla_q[0] <= '{dsg: dsg_s4, gsg: gsg_s4, gsc: gsc_s4, dz: dz_s4, gz: gz_s4};
		for (int k = 1; k < NORM_LAT; k++) begin
			dla_q[k] <= dla_q[k-1];
		end
	end

	assign sa_c = dla_q[NORM_LAT-1];

	// Put the signs back on forward and on the scaled guide.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fw_c[i] = sa_c.dsg[i] ? -$signed({1'b0, fa_quo[i]}) : $signed({1'b0, fa_quo[i]});
			gs_c[i] = sa_c.gsg[i] ? -$signed({1'b0, sa_c.gsc[i]})
				: $signed({1'b0, sa_c.gsc[i]});
		end
	end

	// Middle section: right = cross(guide, forward), then block scaling.
	always_ff @(posedge clk) begin
		cp_s5[0] <= gs_c[1] * fw_c[2];
		cp_s5[1] <= gs_c[2] * fw_c[1];
		cp_s5[2] <= gs_c[2] * fw_c[0];
		cp_s5[3] <= gs_c[0] * fw_c[2];
		cp_s5[4] <= gs_c[0] * fw_c[1];
		cp_s5[5] <= gs_c[1] * fw_c[0];
		fw_s5    <= fw_c;
		bad_s5   <= sa_c.dz | sa_c.gz;

		for (int i = 0; i < 3; i++) begin
			cr_s6[i] <= CR_W'(cp_s5[2*i]) - CR_W'(cp_s5[2*i+1]);
		end
		fw_s6  <= fw_s5;
		bad_s6 <= bad_s5;

		for (int i = 0; i < 3; i++) begin
			crm_s7[i] <= SC_W'($unsigned(cr_s6[i][CR_W-1] ? -cr_s6[i] : cr_s6[i]));
			crs_s7[i] <= cr_s6[i][CR_W-1];
		end
		fw_s7  <= fw_s6;
		bad_s7 <= bad_s6;

		crm_s8 <= crm_s7;
		crs_s8 <= crs_s7;
		crp_s8 <= msb_pos(crm_s7[0] | crm_s7[1] | crm_s7[2]);
		crz_s8 <= ~|(crm_s7[0] | crm_s7[1] | crm_s7[2]);
		fw_s8  <= fw_s7;
		bad_s8 <= bad_s7;

		for (int i = 0; i < 3; i++) begin
			crsc_s9[i] <= block_shift(crm_s8[i], crp_s8);
		end
		crs_s9 <= crs_s8;
		fw_s9  <= fw_s8;
		bad_s9 <= bad_s8 | crz_s8;
	end

	lacb_norm u_norm_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (v_s9),
		.mag     (crsc_s9),
		.out_vld (fb_vld),
		.quo     (fb_quo)
	);

	// Forward and the degenerate flag wait out the second normalizer.
	always_ff @(posedge clk) begin
		dlb_q[0].rsg <= crs_s9;
		dlb_q[0].bad <= bad_s9;
		for (int i = 0; i < 3; i++) begin
			dlb_q[0].fw[i] <= fw_s9[i];
		end
		for (int k = 1; k < NORM_LAT; k++) begin
			dlb_q[k] <= dlb_q[k-1];
		end
	end

	assign sb_c = dlb_q[NORM_LAT-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rt_c[i]  = sb_c.rsg[i] ? -$signed({1'b0, fb_quo[i]}) : $signed({1'b0, fb_quo[i]});
			fwb_c[i] = $signed(sb_c.fw[i]);
		end
	end

	// Back section: up = cross(forward, right), rounded and saturated.
	always_ff @(posedge clk) begin
		upp_s10[0] <= fwb_c[1] * rt_c[2];
		upp_s10[1] <= fwb_c[2] * rt_c[1];
		upp_s10[2] <= fwb_c[2] * rt_c[0];
		upp_s10[3] <= fwb_c[0] * rt_c[2];
		upp_s10[4] <= fwb_c[0] * rt_c[1];
		upp_s10[5] <= fwb_c[1] * rt_c[0];
		rt_s10     <= rt_c;
		fw_s10     <= fwb_c;
		bad_s10    <= sb_c.bad;

		for (int i = 0; i < 3; i++) begin
			ud_s11[i] <= UP_W'(upp_s10[2*i]) - UP_W'(upp_s10[2*i+1]);
		end
		rt_s11  <= rt_s10;
		fw_s11  <= fw_s10;
		bad_s11 <= bad_s10;

		for (int i = 0; i < 3; i++) begin
			um_s12[i] <= $unsigned(ud_s11[i][UP_W-1] ? -ud_s11[i] : ud_s11[i]);
			us_s12[i] <= ud_s11[i][UP_W-1];
		end
		rt_s12  <= rt_s11;
		fw_s12  <= fw_s11;
		bad_s12 <= bad_s11;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd_c[i] = (um_s12[i] + UP_HALF) >> UNIT_FRAC_BITS;
			if (rnd_c[i] > UP_SAT) begin
				rnd_c[i] = UP_SAT;
			end
			up_c[i] = us_s12[i] ? -$signed(OUT_WIDTH'(rnd_c[i])) : $signed(OUT_WIDTH'(rnd_c[i]));
		end
	end

	// Output register; a degenerate item carries an all-zero basis.
	always_ff @(posedge clk) begin
		if (bad_s12) begin
			res_q            <= '0;
			res_q.degenerate <= 1'b1;
		end else begin
			res_q.right_x    <= rt_s12[0];
			res_q.right_y    <= rt_s12[1];
			res_q.right_z    <= rt_s12[2];
			res_q.upvec_x    <= up_c[0];
			res_q.upvec_y    <= up_c[1];
			res_q.upvec_z    <= up_c[2];
			res_q.fwd_x      <= fw_s12[0];
			res_q.fwd_y      <= fw_s12[1];
			res_q.fwd_z      <= fw_s12[2];
			res_q.degenerate <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign res  = res_q;

endmodule

// ----- hdl/lacb_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lacb_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input lacb_pkg::lacb_out_t res
);
	import lacb_pkg::*;

	logic basis_zero;
	logic unit_overrange;

	assign basis_zero = (res.right_x == '0) && (res.right_y == '0) && (res.right_z == '0)
		&& (res.upvec_x == '0) && (res.upvec_y == '0) && (res.upvec_z == '0)
		&& (res.fwd_x == '0) && (res.fwd_y == '0) && (res.fwd_z == '0);

	assign unit_overrange = (res.fwd_x > UNIT_ONE) || (res.fwd_x < -UNIT_ONE)
		|| (res.right_x > UNIT_ONE) || (res.right_x < -UNIT_ONE)
		|| (res.upvec_x > UNIT_ONE) || (res.upvec_x < -UNIT_ONE);

	// A result only ever appears a fixed pipeline depth after an accepted item.
	`LACB_ASSERT_IMPLIES(a_done_latency, clk, arst_n, done, $past(start && !busy, PIPE_LAT))

	// A degenerate result carries an all-zero basis.
	`LACB_ASSERT_IMPLIES(a_degen_zero, clk, arst_n, done && res.degenerate, basis_zero)

	// A regular result has a nonzero forward vector.
	`LACB_ASSERT_IMPLIES(a_fwd_nonzero, clk, arst_n, done && !res.degenerate, res.fwd_x != 0 || res.fwd_y != 0 || res.fwd_z != 0)

	// The x component of each unit vector stays within one unit.
	`LACB_ASSERT_NEVER(a_unit_range, clk, arst_n, done && unit_overrange)

endmodule

bind look_at_camera_basis_core lacb_checker u_lacb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.res    (res)
);
